// File: rtl/orc_pkg.sv
// ----------------------------------------------------------------------------
// orc_pkg: shared constants for the oriented rectangle corner block
// Angle units, CORDIC gain, the arctangent table and register codes.
// ----------------------------------------------------------------------------
package orc_pkg;

  // Angles are held in units of 2^-24 turn, with two spare bits for sign and range.
  localparam int ANG_W = 26;
  // Sine and cosine are signed Q4.30, with headroom for the CORDIC swing.
  localparam int TRIG_W = 34;
  localparam int CFG_W = 24;
  localparam int HEAD_W = 16;

  localparam logic signed [ANG_W-1:0] FULL_TURN    = 26'sd16777216;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 26'sd8388608;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd4194304;
  localparam logic signed [ANG_W-1:0] ROUND_HALF   = 26'sd128;
  localparam logic signed [TRIG_W-1:0] GAIN_INV    = 34'sd652032874;
  localparam logic [HEAD_W-1:0] HEAD_VERTICAL      = 16'd16384;
  localparam logic [CFG_W-1:0] CFG_RESET           = 24'd65536;

  typedef enum logic {
    REG_HALF_LENGTH = 1'b0,
    REG_HALF_WIDTH  = 1'b1
  } cfg_reg_e;

  // Rounded arctangent of 2^-i in units of 2^-24 turn.
  function automatic logic [23:0] atan_entry(input int i);
    logic [23:0] v;
    case (i)
      0: v = 24'd2097152;   1: v = 24'd1238021;   2: v = 24'd654136;
      3: v = 24'd332050;    4: v = 24'd166669;    5: v = 24'd83416;
      6: v = 24'd41718;     7: v = 24'd20860;     8: v = 24'd10430;
      9: v = 24'd5215;      10: v = 24'd2608;     11: v = 24'd1304;
      12: v = 24'd652;      13: v = 24'd326;      14: v = 24'd163;
      15: v = 24'd81;       16: v = 24'd41;       17: v = 24'd20;
      18: v = 24'd10;       19: v = 24'd5;        20: v = 24'd3;
      21: v = 24'd1;        22: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/orc_in_if.sv
// ----------------------------------------------------------------------------
// orc_in_if: input channel
// Carries one placement beat: centre point and aim point.
// ----------------------------------------------------------------------------
interface orc_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] center_x;
  logic signed [W-1:0] center_y;
  logic signed [W-1:0] aim_x;
  logic signed [W-1:0] aim_y;

  modport source(output valid, center_x, center_y, aim_x, aim_y, input ready);
  modport sink(input valid, center_x, center_y, aim_x, aim_y, output ready);
endinterface

// File: rtl/orc_out_if.sv
// ----------------------------------------------------------------------------
// orc_out_if: result channel
// Carries one result beat: heading and four rectangle corners.
// ----------------------------------------------------------------------------
interface orc_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic [15:0]         heading;
  logic signed [W-1:0] corner_a_x;
  logic signed [W-1:0] corner_a_y;
  logic signed [W-1:0] corner_b_x;
  logic signed [W-1:0] corner_b_y;
  logic signed [W-1:0] corner_c_x;
  logic signed [W-1:0] corner_c_y;
  logic signed [W-1:0] corner_d_x;
  logic signed [W-1:0] corner_d_y;

  modport source(output valid, heading, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                 corner_c_x, corner_c_y, corner_d_x, corner_d_y, input ready);
  modport sink(input valid, heading, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
               corner_c_x, corner_c_y, corner_d_x, corner_d_y, output ready);
endinterface

// File: rtl/oriented_rectangle_corners.sv
// ----------------------------------------------------------------------------
// oriented_rectangle_corners: heading and corners of an oriented rectangle
// Finds the heading from a centre towards an aim point and places a rectangle
// of programmable half length and half width, rotated to that heading.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   in_i      sink       center_x, center_y, aim_x, aim_y (signed Q16.16)
//   out_o     source     heading (binary angle), corners a..d (signed Q16.16)
//   APB       slave      half_length at 0x0, half_width at 0x4 (24 bits)
//
// A beat passes, in order, through one input register, ANGLE_STAGES
// vectoring cells, ANGLE_STAGES rotation cells, one multiply register and the
// output register. A new beat may enter every cycle while the pipeline moves.
// The whole pipeline advances together; it holds only while the output
// register is full and the sink is not ready. Reset clears all valid bits and
// sets both half sizes to 1.0.
// ----------------------------------------------------------------------------
module oriented_rectangle_corners
  import orc_pkg::*;
#(
  parameter int COORD_WIDTH  = 32,
  parameter int ANGLE_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  orc_in_if.sink             in_i,
  orc_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int W      = COORD_WIDTH;
  localparam int N      = ANGLE_STAGES;
  localparam int DW     = W + 1;          // exact difference of two coordinates
  localparam int VW     = W + 3;          // vectoring datapath with CORDIC growth
  localparam int PW     = CFG_W + 1 + TRIG_W;
  localparam int RW     = PW - 30;        // rounded product
  localparam int SUM_W  = ((W > RW) ? W : RW) + 2;
  localparam int VSW    = 2 * W + 1;      // centre and vertical flag
  localparam int RSW    = 2 * W + HEAD_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers. Only bit 2 of the address picks the register.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] half_length_q, half_width_q;
  logic             cfg_wr;
  cfg_reg_e         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_length_q <= CFG_RESET;
      half_width_q  <= CFG_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_HALF_LENGTH: half_length_q <= pwdata[CFG_W-1:0];
        REG_HALF_WIDTH:  half_width_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_HALF_LENGTH: prdata = {{(32-CFG_W){1'b0}}, half_length_q};
      REG_HALF_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, half_width_q};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: every stage moves when the output register can take a beat.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic en;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // Input register: differences towards the aim point.
  // --------------------------------------------------------------------------
  logic                 s0_valid_q;
  logic signed [W-1:0]  s0_cx_q, s0_cy_q;
  logic signed [DW-1:0] s0_dx_q, s0_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_cx_q <= in_i.center_x;
      s0_cy_q <= in_i.center_y;
      s0_dx_q <= DW'(in_i.aim_x) - DW'(in_i.center_x);
      s0_dy_q <= DW'(in_i.aim_y) - DW'(in_i.center_y);
    end
  end

  // A vector pointing left is turned round and starts from a half turn.
  logic                    s0_vert, s0_neg;
  logic signed [VW-1:0]    vx0, vy0;
  logic signed [ANG_W-1:0] vz0;

  assign s0_vert = (s0_dx_q == '0);
  assign s0_neg  = s0_dx_q[DW-1];
  assign vx0     = s0_neg ? -VW'(s0_dx_q) : VW'(s0_dx_q);
  assign vy0     = s0_neg ? -VW'(s0_dy_q) : VW'(s0_dy_q);
  assign vz0     = s0_neg ? HALF_TURN : '0;

  // --------------------------------------------------------------------------
  // Vectoring chain.
  // --------------------------------------------------------------------------
  logic                    vv   [0:N];
  logic signed [VW-1:0]    vx   [0:N];
  logic signed [VW-1:0]    vy   [0:N];
  logic signed [ANG_W-1:0] vz   [0:N];
  logic [VSW-1:0]          vs   [0:N];

  assign vv[0] = s0_valid_q;
  assign vx[0] = vx0;
  assign vy[0] = vy0;
  assign vz[0] = vz0;
  assign vs[0] = {s0_cx_q, s0_cy_q, s0_vert};

  for (genvar i = 0; i < N; i++) begin : g_vec
    orc_vec_cell #(.IDX(i), .VW(VW), .SW(VSW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vv[i]),
      .x_i     (vx[i]),
      .y_i     (vy[i]),
      .z_i     (vz[i]),
      .side_i  (vs[i]),
      .valid_o (vv[i+1]),
      .x_o     (vx[i+1]),
      .y_o     (vy[i+1]),
      .z_o     (vz[i+1]),
      .side_o  (vs[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Heading rounding and folding into the right half plane.
  // --------------------------------------------------------------------------
  logic signed [W-1:0]     v_cx, v_cy;
  logic                    v_vert;
  logic signed [ANG_W-1:0] hsum;
  logic [HEAD_W-1:0]       heading;
  logic signed [ANG_W-1:0] zs, rz0;
  logic                    flip;

  assign {v_cx, v_cy, v_vert} = vs[N];
  assign hsum    = vz[N] + ROUND_HALF;
  assign heading = v_vert ? HEAD_VERTICAL : hsum[23:8];

  always_comb begin
    zs   = $signed({2'b00, heading, 8'h00});
    if (heading[HEAD_W-1]) begin
      zs = zs - FULL_TURN;
    end
    flip = 1'b0;
    rz0  = zs;
    if (zs > QUARTER_TURN) begin
      rz0  = zs - HALF_TURN;
      flip = 1'b1;
    end else if (zs < -QUARTER_TURN) begin
      rz0  = zs + HALF_TURN;
      flip = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Rotation chain.
  // --------------------------------------------------------------------------
  logic                     rv [0:N];
  logic signed [TRIG_W-1:0] rx [0:N];
  logic signed [TRIG_W-1:0] ry [0:N];
  logic signed [ANG_W-1:0]  rz [0:N];
  logic [RSW-1:0]           rs [0:N];

  assign rv[0] = vv[N];
  assign rx[0] = GAIN_INV;
  assign ry[0] = '0;
  assign rz[0] = rz0;
  assign rs[0] = {v_cx, v_cy, heading, flip};

  for (genvar i = 0; i < N; i++) begin : g_rot
    orc_rot_cell #(.IDX(i), .SW(RSW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rv[i]),
      .x_i     (rx[i]),
      .y_i     (ry[i]),
      .z_i     (rz[i]),
      .side_i  (rs[i]),
      .valid_o (rv[i+1]),
      .x_o     (rx[i+1]),
      .y_o     (ry[i+1]),
      .z_o     (rz[i+1]),
      .side_o  (rs[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Multiply stage: half sizes times cosine and sine.
  // --------------------------------------------------------------------------
  logic signed [W-1:0]      r_cx, r_cy;
  logic [HEAD_W-1:0]        r_head;
  logic                     r_flip;
  logic signed [TRIG_W-1:0] cosv, sinv;
  logic signed [CFG_W:0]    hl_s, hw_s;

  assign {r_cx, r_cy, r_head, r_flip} = rs[N];
  assign cosv = r_flip ? -rx[N] : rx[N];
  assign sinv = r_flip ? -ry[N] : ry[N];
  assign hl_s = $signed({1'b0, half_length_q});
  assign hw_s = $signed({1'b0, half_width_q});

  logic                 m_valid_q;
  logic signed [W-1:0]  m_cx_q, m_cy_q;
  logic [HEAD_W-1:0]    m_head_q;
  logic signed [PW-1:0] m_lc_q, m_ls_q, m_wc_q, m_ws_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= rv[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_cx_q   <= r_cx;
      m_cy_q   <= r_cy;
      m_head_q <= r_head;
      m_lc_q   <= PW'(hl_s) * PW'(cosv);
      m_ls_q   <= PW'(hl_s) * PW'(sinv);
      m_wc_q   <= PW'(hw_s) * PW'(cosv);
      m_ws_q   <= PW'(hw_s) * PW'(sinv);
    end
  end

  // --------------------------------------------------------------------------
  // Rounding, corner sums and saturation.
  // --------------------------------------------------------------------------
  localparam logic signed [PW-1:0] RND = PW'(1) <<< 29;

  logic signed [PW-1:0]    lc_r, ls_r, wc_r, ws_r;
  logic signed [SUM_W-1:0] lc, ls, wc, ws, cxe, cye;
  logic signed [SUM_W-1:0] sums [0:7];
  logic signed [W-1:0]     sat  [0:7];
  logic signed [SUM_W-1:0] hi_lim, lo_lim;

  assign lc_r = (m_lc_q + RND) >>> 30;
  assign ls_r = (m_ls_q + RND) >>> 30;
  assign wc_r = (m_wc_q + RND) >>> 30;
  assign ws_r = (m_ws_q + RND) >>> 30;
  // The rounded products are signed; extend them by their sign bit.
  assign lc   = SUM_W'($signed(lc_r[RW-1:0]));
  assign ls   = SUM_W'($signed(ls_r[RW-1:0]));
  assign wc   = SUM_W'($signed(wc_r[RW-1:0]));
  assign ws   = SUM_W'($signed(ws_r[RW-1:0]));
  assign cxe  = SUM_W'(m_cx_q);
  assign cye  = SUM_W'(m_cy_q);

  assign hi_lim = SUM_W'($signed({1'b0, {(W-1){1'b1}}}));
  assign lo_lim = SUM_W'($signed({1'b1, {(W-1){1'b0}}}));

  assign sums[0] = cxe + lc - ws;
  assign sums[1] = cye + ls + wc;
  assign sums[2] = cxe + lc + ws;
  assign sums[3] = cye + ls - wc;
  assign sums[4] = cxe - lc + ws;
  assign sums[5] = cye - ls - wc;
  assign sums[6] = cxe - lc - ws;
  assign sums[7] = cye - ls + wc;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (sums[k] > hi_lim) begin
        sat[k] = hi_lim[W-1:0];
      end else if (sums[k] < lo_lim) begin
        sat[k] = lo_lim[W-1:0];
      end else begin
        sat[k] = sums[k][W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic [HEAD_W-1:0]   o_head_q;
  logic signed [W-1:0] o_c_q [0:7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_head_q <= m_head_q;
      for (int k = 0; k < 8; k++) begin
        o_c_q[k] <= sat[k];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.heading    = o_head_q;
  assign out_o.corner_a_x = o_c_q[0];
  assign out_o.corner_a_y = o_c_q[1];
  assign out_o.corner_b_x = o_c_q[2];
  assign out_o.corner_b_y = o_c_q[3];
  assign out_o.corner_c_x = o_c_q[4];
  assign out_o.corner_c_y = o_c_q[5];
  assign out_o.corner_d_x = o_c_q[6];
  assign out_o.corner_d_y = o_c_q[7];

endmodule

// File: rtl/orc_vec_cell.sv
// ----------------------------------------------------------------------------
// orc_vec_cell: one vectoring CORDIC cell
// Rotates the vector towards the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module orc_vec_cell
  import orc_pkg::*;
#(
  parameter int IDX = 0,
  parameter int VW  = 35,
  parameter int SW  = 65
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [VW-1:0]    x_i,
  input  logic signed [VW-1:0]    y_i,
  input  logic signed [ANG_W-1:0] z_i,
  input  logic [SW-1:0]           side_i,
  output logic                    valid_o,
  output logic signed [VW-1:0]    x_o,
  output logic signed [VW-1:0]    y_o,
  output logic signed [ANG_W-1:0] z_o,
  output logic [SW-1:0]           side_o
);

  logic signed [VW-1:0]    xs, ys;
  logic signed [ANG_W-1:0] ang;

  assign xs  = x_i >>> IDX;
  assign ys  = y_i >>> IDX;
  assign ang = $signed({2'b00, atan_entry(IDX)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      if (y_i[VW-1]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - ang;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + ang;
      end
    end
  end

endmodule

// File: rtl/orc_rot_cell.sv
// ----------------------------------------------------------------------------
// orc_rot_cell: one rotation CORDIC cell
// Turns the unit vector by one table step, driving the residual angle to zero.
// ----------------------------------------------------------------------------
module orc_rot_cell
  import orc_pkg::*;
#(
  parameter int IDX = 0,
  parameter int SW  = 81
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [TRIG_W-1:0] x_i,
  input  logic signed [TRIG_W-1:0] y_i,
  input  logic signed [ANG_W-1:0]  z_i,
  input  logic [SW-1:0]            side_i,
  output logic                     valid_o,
  output logic signed [TRIG_W-1:0] x_o,
  output logic signed [TRIG_W-1:0] y_o,
  output logic signed [ANG_W-1:0]  z_o,
  output logic [SW-1:0]            side_o
);

  logic signed [TRIG_W-1:0] xs, ys;
  logic signed [ANG_W-1:0]  ang;

  assign xs  = x_i >>> IDX;
  assign ys  = y_i >>> IDX;
  assign ang = $signed({2'b00, atan_entry(IDX)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      if (!z_i[ANG_W-1]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - ang;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + ang;
      end
    end
  end

endmodule

// File: rtl/orc_checker.sv
// ----------------------------------------------------------------------------
// orc_checker: port checks for the oriented rectangle corner block
// Watches the result channel and the register port.
// ----------------------------------------------------------------------------
module orc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_heading,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // With the result register empty the block must take a new beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_valid |-> in_ready)
    else $error("input stalled while the result register is empty");

  // A stalled result beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_heading))
    else $error("result beat changed while stalled");

  // A register reads back what was last written to it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=>
      (paddr[2] != $past(paddr[2])) || (prdata == {8'h00, $past(pwdata[23:0])}))
    else $error("register read-back mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind oriented_rectangle_corners orc_checker u_orc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_heading (out_o.heading),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

// File: bench/orc_bench_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orc_bench_pkg: prediction of the oriented rectangle corner block
// Computes the heading and the saturated corners of one placement beat.
// ----------------------------------------------------------------------------
package orc_bench_pkg;
  import orc_pkg::*;

  localparam int CW     = 32;
  localparam int STAGES = 16;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
  } placement_t;

  typedef struct packed {
    logic [HEAD_W-1:0]    heading;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] d_x;
    logic signed [CW-1:0] d_y;
  } corners_t;

  // Arctangent of 2^-i in units of 2^-24 turn.
  function automatic longint arctan_step(input int i);
    longint steps[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                          20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
                          20, 10, 5, 3, 1, 1, 0};
    return steps[i];
  endfunction

  function automatic logic [HEAD_W-1:0] aim_heading(input longint dx, input longint dy);
    longint x, y, z, xs, ys;
    x = dx;
    y = dy;
    z = 0;
    if (dx == 0) return HEAD_VERTICAL;
    if (dx < 0) begin
      x = -dx;
      y = -dy;
      z = 8388608;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    return HEAD_W'((z + 128) >>> 8);
  endfunction

  function automatic void heading_trig(input logic [HEAD_W-1:0] h, output longint cosv,
                                       output longint sinv);
    longint x, y, z, xs, ys;
    bit flip;
    z = longint'(h) << 8;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= 8388608) z -= 16777216;
    if (z > 4194304) begin
      z -= 8388608; flip = 1;
    end else if (z < -4194304) begin
      z += 8388608; flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cosv = x;
    sinv = y;
  endfunction

  function automatic longint scale_trig(input longint mag, input longint t);
    return (mag * t + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic signed [CW-1:0] clamp(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return CW'(v);
  endfunction

  function automatic corners_t place_rectangle(input placement_t p, input longint hl,
                                               input longint hw);
    corners_t r;
    longint cx, cy, cosv, sinv, lc, ls, wc, ws;
    cx = p.cx;
    cy = p.cy;
    r.heading = aim_heading(longint'(p.ax) - cx, longint'(p.ay) - cy);
    heading_trig(r.heading, cosv, sinv);
    lc = scale_trig(hl, cosv);
    ls = scale_trig(hl, sinv);
    wc = scale_trig(hw, cosv);
    ws = scale_trig(hw, sinv);
    r.a_x = clamp(cx + lc - ws);
    r.a_y = clamp(cy + ls + wc);
    r.b_x = clamp(cx + lc + ws);
    r.b_y = clamp(cy + ls - wc);
    r.c_x = clamp(cx - lc + ws);
    r.c_y = clamp(cy - ls - wc);
    r.d_x = clamp(cx - lc - ws);
    r.d_y = clamp(cy - ls + wc);
    return r;
  endfunction

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for the oriented rectangle corner block
// Drives placement beats, programs the half sizes over APB between phases
// and checks every result beat against a bit-exact prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import orc_pkg::*;
  import orc_bench_pkg::*;

  // The pipeline holds 2*16+3 beats; the drain wait allows a little more.
  localparam int PIPE_DEPTH = 35;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  orc_in_if  #(.W(CW)) in_ch ();
  orc_out_if #(.W(CW)) out_ch ();

  oriented_rectangle_corners dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  // Current half sizes, as the block should hold them.
  longint half_length_q = 65536;
  longint half_width_q  = 65536;
  corners_t pending_corners[$];
  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 0;

  // A directed row; the expected corners are typed only where obvious.
  typedef struct {
    placement_t p;
    bit         typed;
    corners_t   want;
  } directed_row_t;

  initial begin
    rst_ni = 1'b0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.center_x = 0; in_ch.center_y = 0; in_ch.aim_x = 0;
    in_ch.aim_y = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random stalls, and a long hold-off when the sender asks for it.
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk_i);
      if (recv_hold) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: each accepted result beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    corners_t want, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.heading, out_ch.corner_a_x, out_ch.corner_a_y, out_ch.corner_b_x,
              out_ch.corner_b_y, out_ch.corner_c_x, out_ch.corner_c_y,
              out_ch.corner_d_x, out_ch.corner_d_y};
      if (pending_corners.size() == 0) begin
        $error("result beat with no placement outstanding");
        fail_count++;
      end else begin
        want = pending_corners.pop_front();
        if (got.heading != want.heading) begin
          $error("heading: expected %0d, got %0d", want.heading, got.heading); fail_count++;
        end
        if (got.a_x != want.a_x) begin
          $error("corner_a_x: expected %0d, got %0d", want.a_x, got.a_x); fail_count++;
        end
        if (got.a_y != want.a_y) begin
          $error("corner_a_y: expected %0d, got %0d", want.a_y, got.a_y); fail_count++;
        end
        if (got.b_x != want.b_x) begin
          $error("corner_b_x: expected %0d, got %0d", want.b_x, got.b_x); fail_count++;
        end
        if (got.b_y != want.b_y) begin
          $error("corner_b_y: expected %0d, got %0d", want.b_y, got.b_y); fail_count++;
        end
        if (got.c_x != want.c_x) begin
          $error("corner_c_x: expected %0d, got %0d", want.c_x, got.c_x); fail_count++;
        end
        if (got.c_y != want.c_y) begin
          $error("corner_c_y: expected %0d, got %0d", want.c_y, got.c_y); fail_count++;
        end
        if (got.d_x != want.d_x) begin
          $error("corner_d_x: expected %0d, got %0d", want.d_x, got.d_x); fail_count++;
        end
        if (got.d_y != want.d_y) begin
          $error("corner_d_y: expected %0d, got %0d", want.d_y, got.d_y); fail_count++;
        end
      end
    end
  end

  // One APB write: setup cycle, then access cycle until pready.
  task automatic apb_write(input cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'(4 * int'(idx)); pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    // The block keeps only the low 24 bits.
    if (idx == REG_HALF_LENGTH) half_length_q = value[23:0];
    else half_width_q = value[23:0];
  endtask

  // Offers one placement beat with a random gap first; the prediction is
  // queued at the edge that accepts it. Valid stays high afterwards so that
  // the next beat can follow at once; whoever waits next drops it.
  task automatic offer_placement(input placement_t p, input bit typed, input corners_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.center_x <= p.cx; in_ch.center_y <= p.cy;
    in_ch.aim_x <= p.ax; in_ch.aim_y <= p.ay;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_corners.push_back(typed ? want : place_rectangle(p, half_length_q, half_width_q));
  endtask

  task automatic drain_results();
    in_ch.valid <= 0;
    do @(posedge clk_i); while (pending_corners.size() != 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // Random coordinates: mostly moderate, sometimes anywhere in the range.
  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return 32'($signed($urandom_range(200000000)) - 100000000);
    endcase
  endfunction

  function automatic placement_t rand_placement();
    placement_t p;
    p.cx = rand_coord();
    p.cy = rand_coord();
    case ($urandom_range(9))
      0: begin
        p.ax = p.cx; p.ay = rand_coord();
      end
      1: begin
        p.ax = rand_coord(); p.ay = p.cy;
      end
      default: begin
        p.ax = rand_coord(); p.ay = rand_coord();
      end
    endcase
    return p;
  endfunction

  localparam logic signed [31:0] MAXC = 32'sh7fffffff;
  localparam logic signed [31:0] MINC = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sd65536;

  initial begin
    directed_row_t rows[$];
    corners_t none;
    none = '0;
    // Vertical aim at origin with unit sizes: heading is a quarter turn.
    rows.push_back('{'{0, 0, 0, ONE}, 0, none});
    rows.push_back('{'{0, 0, 0, -ONE}, 0, none});
    rows.push_back('{'{0, 0, 0, 0}, 0, none});
    rows.push_back('{'{0, 0, ONE, 0}, 0, none});
    rows.push_back('{'{0, 0, -ONE, 0}, 0, none});
    rows.push_back('{'{ONE, ONE, 2 * ONE, 2 * ONE}, 0, none});
    rows.push_back('{'{0, 0, -ONE, -ONE}, 0, none});
    rows.push_back('{'{MAXC, MAXC, MINC, MINC}, 0, none});
    rows.push_back('{'{MINC, MINC, MAXC, MAXC}, 0, none});
    rows.push_back('{'{MINC, MAXC, MAXC, MINC}, 0, none});
    // Centre at the top corner, vertical aim: several corners saturate high.
    rows.push_back('{'{MAXC, MAXC, MAXC, 0}, 0, none});
    rows.push_back('{'{MINC, MINC, MINC, 0}, 0, none});
    rows.push_back('{'{0, 0, 32'sh55555555, 32'shaaaaaaaa}, 0, none});
    rows.push_back('{'{32'shaaaaaaaa, 32'sh55555555, 0, 0}, 0, none});

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (rows[i]) offer_placement(rows[i].p, rows[i].typed, rows[i].want);
    drain_results();

    // Extremes of the registers, with bits above the 24 kept ignored.
    apb_write(REG_HALF_LENGTH, 32'hff_ffffff);
    apb_write(REG_HALF_WIDTH, 32'h00_000000);
    foreach (rows[i]) offer_placement(rows[i].p, 0, none);
    drain_results();
    apb_write(REG_HALF_LENGTH, 32'h0);
    apb_write(REG_HALF_WIDTH, 32'h00ffffff);
    foreach (rows[i]) offer_placement(rows[i].p, 0, none);
    drain_results();

    // Zero-sized rectangle: every corner sits on the centre.
    apb_write(REG_HALF_WIDTH, 32'h0);
    offer_placement('{ONE, -ONE, ONE, 5 * ONE}, 1,
      '{HEAD_VERTICAL, ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE});
    drain_results();

    // Random phases, each with fresh half sizes and its own idling pattern.
    for (int ph = 0; ph < 3; ph++) begin
      apb_write(REG_HALF_LENGTH, $urandom());
      apb_write(REG_HALF_WIDTH, $urandom_range(1 << 20));
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 83 : 0;
      recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 25 : 0;
      for (int n = 0; n < 440; n++) begin
        if (ph == 2 && n == 100) begin
          // Long receiver hold-off while beats keep coming.
          fork
            begin
              recv_hold = 1;
              repeat (200) @(posedge clk_i);
              recv_hold = 0;
            end
          join_none
        end
        if (n == 300) begin
          // Sender pause until everything outstanding has come back.
          in_ch.valid <= 0;
          do @(posedge clk_i); while (pending_corners.size() != 0);
        end
        offer_placement(rand_placement(), 0, none);
      end
      drain_results();
    end

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
